@@ hw/rtl/vpcs_pkg.sv @@
// Package for the spindle-drive polling sequencer: beat types, event and
// function codes, sweep steps and register reset values. No dependencies.
package vpcs_pkg;

   // event codes carried in op
   localparam logic [2:0] OP_START     = 3'd0;
   localparam logic [2:0] OP_RESP_OK   = 3'd1;
   localparam logic [2:0] OP_RESP_FAIL = 3'd2;
   localparam logic [2:0] OP_SET_POWER = 3'd3;
   localparam logic [2:0] OP_SHUTDOWN  = 3'd4;

   // link function codes
   localparam logic [7:0] FUNC_PARAM_READ = 8'd1;
   localparam logic [7:0] FUNC_CTRL_WRITE = 8'd3;
   localparam logic [7:0] FUNC_CTRL_READ  = 8'd4;
   localparam logic [7:0] FUNC_FREQ_WRITE = 8'd5;

   // control words for the direction write
   localparam logic [7:0] CTL_STOP    = 8'd8;
   localparam logic [7:0] CTL_RUN_FWD = 8'd3;
   localparam logic [7:0] CTL_RUN_REV = 8'd17;

   // status addresses for control reads
   localparam logic [7:0] STAT_FREQ    = 8'd1;
   localparam logic [7:0] STAT_CURRENT = 8'd2;
   localparam logic [7:0] STAT_RPM     = 8'd3;
   localparam logic [7:0] STAT_TEMP    = 8'd7;

   // update selectors
   localparam logic [2:0] UPD_MAX_FREQ  = 3'd0;
   localparam logic [2:0] UPD_MIN_FREQ  = 3'd1;
   localparam logic [2:0] UPD_RPM_RATED = 3'd2;
   localparam logic [2:0] UPD_FREQ      = 3'd3;
   localparam logic [2:0] UPD_CURRENT   = 3'd4;
   localparam logic [2:0] UPD_RPM       = 3'd5;
   localparam logic [2:0] UPD_TEMP      = 3'd6;
   localparam logic [2:0] UPD_STATUS    = 3'd7;

   // sweep positions
   localparam logic [3:0] STEP_DIR_WRITE = 4'd0;
   localparam logic [3:0] STEP_MAX_READ  = 4'd1;
   localparam logic [3:0] STEP_MIN_READ  = 4'd2;
   localparam logic [3:0] STEP_RPM_READ  = 4'd3;
   localparam logic [3:0] STEP_FREQ_WR   = 4'd4;
   localparam logic [3:0] STEP_POLL_FREQ = 4'd5;
   localparam logic [3:0] STEP_POLL_CUR  = 4'd6;
   localparam logic [3:0] STEP_POLL_RPM  = 4'd7;
   localparam logic [3:0] STEP_POLL_TEMP = 4'd8;
   localparam logic [3:0] STEP_END       = 4'd9;

   // configuration register indexes and reset values
   localparam logic [1:0] CSR_MAX_ADDR = 2'd0;
   localparam logic [1:0] CSR_MIN_ADDR = 2'd1;
   localparam logic [1:0] CSR_RPM_ADDR = 2'd2;

   localparam logic [7:0] MAX_ADDR_RESET = 8'd5;
   localparam logic [7:0] MIN_ADDR_RESET = 8'd11;
   localparam logic [7:0] RPM_ADDR_RESET = 8'd144;

   typedef struct packed {
      logic [2:0]         op;
      logic               estop;
      logic signed [15:0] power;
      logic [7:0]         resp_func;
      logic [7:0]         resp_count;
      logic [7:0]         resp_len_byte;
      logic [7:0]         resp_first;
      logic [7:0]         resp_word_hi;
      logic [7:0]         resp_word_lo;
   } req_beat_type;

   typedef struct packed {
      logic        cmd_valid;
      logic [7:0]  cmd_func;
      logic [7:0]  cmd_byte0;
      logic [7:0]  cmd_byte1;
      logic [7:0]  cmd_byte2;
      logic [1:0]  cmd_nbytes;
      logic [2:0]  resp_expect;
      logic        deinit_done;
      logic        upd_valid;
      logic [2:0]  upd_which;
      logic [15:0] upd_value;
   } rsp_beat_type;

endpackage

@@ hw/rtl/vpcs_req_if.sv @@
// Event channel of the polling sequencer: valid, ready and one event beat.
// Depends on nothing.
interface vpcs_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic               estop;
   logic signed [15:0] power;
   logic [7:0]         resp_func;
   logic [7:0]         resp_count;
   logic [7:0]         resp_len_byte;
   logic [7:0]         resp_first;
   logic [7:0]         resp_word_hi;
   logic [7:0]         resp_word_lo;

   modport source (
      output valid, op, estop, power, resp_func, resp_count, resp_len_byte,
             resp_first, resp_word_hi, resp_word_lo,
      input  ready
   );
   modport sink (
      input  valid, op, estop, power, resp_func, resp_count, resp_len_byte,
             resp_first, resp_word_hi, resp_word_lo,
      output ready
   );
endinterface

@@ hw/rtl/vpcs_rsp_if.sv @@
// Result channel of the polling sequencer: valid, ready, command frame,
// shutdown flag and value update. Depends on nothing.
interface vpcs_rsp_if;
   logic        valid;
   logic        ready;
   logic        cmd_valid;
   logic [7:0]  cmd_func;
   logic [7:0]  cmd_byte0;
   logic [7:0]  cmd_byte1;
   logic [7:0]  cmd_byte2;
   logic [1:0]  cmd_nbytes;
   logic [2:0]  resp_expect;
   logic        deinit_done;
   logic        upd_valid;
   logic [2:0]  upd_which;
   logic [15:0] upd_value;

   modport source (
      output valid, cmd_valid, cmd_func, cmd_byte0, cmd_byte1, cmd_byte2,
             cmd_nbytes, resp_expect, deinit_done, upd_valid, upd_which,
             upd_value,
      input  ready
   );
   modport sink (
      input  valid, cmd_valid, cmd_func, cmd_byte0, cmd_byte1, cmd_byte2,
             cmd_nbytes, resp_expect, deinit_done, upd_valid, upd_which,
             upd_value,
      output ready
   );
endinterface

@@ hw/rtl/vfd_poll_command_sequencer.sv @@
// Spindle-drive polling sequencer, top level.
// Depends on vpcs_pkg, vpcs_req_if and vpcs_rsp_if.
//
//   channel     dir   handshake                 beat
//   req_chan    in    valid/ready               one event (op, estop, power, response)
//   rsp_chan    out   valid/ready               command frame, deinit flag, update
//   csr_*       in    csr_wr_en, no wait        register index and 8-bit value
//
// Each event is held in the input register, then its result in the result
// register. The step decode and the 17x16 frequency multiply sit between those
// two registers, so one event is accepted per cycle unless a held result stalls it.
// Reset (synchronous) clears the sweep state and loads the default parameter
// numbers. A held result stalls only events that produce a result; set power,
// shutdown and dropped responses pass the input register regardless.
module vfd_poll_command_sequencer (
   input  logic       clock,
   input  logic       reset,
   vpcs_req_if.sink   req_chan,
   vpcs_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data
);
   import vpcs_pkg::*;

   // configuration registers
   logic [7:0] max_addr_ff, min_addr_ff, rpm_addr_ff;

   // input stage
   logic         s1_valid_ff;
   req_beat_type s1_beat_ff;
   logic         s1_advance;

   // sweep state
   logic [3:0]  seq_step_ff, seq_step_in;
   logic        shutdown_req_ff, shutdown_req_in;
   logic        power_changed_ff, power_changed_in;
   logic        link_stopped_ff, link_stopped_in;
   logic [15:0] power_now_ff, power_now_in;
   logic [15:0] max_freq_ff, max_freq_in;

   // result stage
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_beat_ff, rsp_beat_in;

   // event decode
   logic        has_result;
   logic        cmd_on;
   logic        count_ok;
   logic [3:0]  step_inc;
   logic [16:0] power_mag;
   logic [32:0] freq_prod;
   logic [15:0] freq_word;
   logic [15:0] resp_word;
   logic [7:0]  ctl_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_addr_ff <= MAX_ADDR_RESET;
         min_addr_ff <= MIN_ADDR_RESET;
         rpm_addr_ff <= RPM_ADDR_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_ADDR: max_addr_ff <= csr_wr_data;
            CSR_MIN_ADDR: min_addr_ff <= csr_wr_data;
            CSR_RPM_ADDR: rpm_addr_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Advance the input beat when it yields nothing, or when the result slot
   // is free or being drained this cycle.
   assign s1_advance = s1_valid_ff & (~has_result | ~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~s1_valid_ff | s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_chan.valid | (s1_valid_ff & ~s1_advance);
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_beat_ff.op            <= req_chan.op;
         s1_beat_ff.estop         <= req_chan.estop;
         s1_beat_ff.power         <= req_chan.power;
         s1_beat_ff.resp_func     <= req_chan.resp_func;
         s1_beat_ff.resp_count    <= req_chan.resp_count;
         s1_beat_ff.resp_len_byte <= req_chan.resp_len_byte;
         s1_beat_ff.resp_first    <= req_chan.resp_first;
         s1_beat_ff.resp_word_hi  <= req_chan.resp_word_hi;
         s1_beat_ff.resp_word_lo  <= req_chan.resp_word_lo;
      end
   end

   assign count_ok  = {1'b0, s1_beat_ff.resp_count} == ({1'b0, s1_beat_ff.resp_len_byte} + 9'd1);
   assign resp_word = {s1_beat_ff.resp_word_hi, s1_beat_ff.resp_word_lo};
   assign step_inc  = seq_step_ff + 4'd1;

   // Event handling: next sweep state, whether a result beat goes out, and
   // whether it carries a command.
   always_comb begin
      seq_step_in      = seq_step_ff;
      shutdown_req_in  = shutdown_req_ff;
      power_changed_in = power_changed_ff;
      link_stopped_in  = link_stopped_ff;
      power_now_in     = power_now_ff;
      max_freq_in      = max_freq_ff;
      has_result       = 1'b0;
      cmd_on           = 1'b0;
      rsp_beat_in      = '0;

      case (s1_beat_ff.op)
         OP_START: begin
            seq_step_in      = STEP_DIR_WRITE;
            shutdown_req_in  = 1'b0;
            power_changed_in = 1'b0;
            link_stopped_in  = 1'b0;
            power_now_in     = '0;
            max_freq_in      = '0;
            has_result       = 1'b1;
            cmd_on           = 1'b1;
         end
         OP_RESP_OK: begin
            if (!link_stopped_ff) begin
               has_result = 1'b1;
               cmd_on     = 1'b1;
               if (count_ok) begin
                  case (s1_beat_ff.resp_func)
                     FUNC_PARAM_READ: begin
                        // max wins over min, min over rated on equal numbers
                        if (s1_beat_ff.resp_first == max_addr_ff) begin
                           max_freq_in           = resp_word;
                           rsp_beat_in.upd_valid = 1'b1;
                           rsp_beat_in.upd_which = UPD_MAX_FREQ;
                           rsp_beat_in.upd_value = resp_word;
                        end else if (s1_beat_ff.resp_first == min_addr_ff) begin
                           rsp_beat_in.upd_valid = 1'b1;
                           rsp_beat_in.upd_which = UPD_MIN_FREQ;
                           rsp_beat_in.upd_value = resp_word;
                        end else if (s1_beat_ff.resp_first == rpm_addr_ff) begin
                           rsp_beat_in.upd_valid = 1'b1;
                           rsp_beat_in.upd_which = UPD_RPM_RATED;
                           rsp_beat_in.upd_value = resp_word;
                        end
                     end
                     FUNC_CTRL_WRITE: begin
                        rsp_beat_in.upd_valid = 1'b1;
                        rsp_beat_in.upd_which = UPD_STATUS;
                        rsp_beat_in.upd_value = {8'd0, s1_beat_ff.resp_first};
                     end
                     FUNC_CTRL_READ: begin
                        case (s1_beat_ff.resp_first)
                           STAT_FREQ: begin
                              rsp_beat_in.upd_valid = 1'b1;
                              rsp_beat_in.upd_which = UPD_FREQ;
                           end
                           STAT_CURRENT: begin
                              rsp_beat_in.upd_valid = 1'b1;
                              rsp_beat_in.upd_which = UPD_CURRENT;
                           end
                           STAT_RPM: begin
                              rsp_beat_in.upd_valid = 1'b1;
                              rsp_beat_in.upd_which = UPD_RPM;
                           end
                           STAT_TEMP: begin
                              rsp_beat_in.upd_valid = 1'b1;
                              rsp_beat_in.upd_which = UPD_TEMP;
                           end
                           default: ;
                        endcase
                        if (rsp_beat_in.upd_valid) rsp_beat_in.upd_value = resp_word;
                     end
                     default: ;
                  endcase

                  if (s1_beat_ff.resp_func == FUNC_CTRL_WRITE &&
                      (shutdown_req_ff || s1_beat_ff.estop)) begin
                     // stop acknowledged: drop the link
                     link_stopped_in         = 1'b1;
                     rsp_beat_in.deinit_done = 1'b1;
                     cmd_on                  = 1'b0;
                  end else if (step_inc == STEP_END) begin
                     // sweep done: full sweep if anything changed, else poll only
                     seq_step_in = (shutdown_req_ff || power_changed_ff) ?
                                   STEP_DIR_WRITE : STEP_POLL_FREQ;
                     power_changed_in = 1'b0;
                  end else begin
                     seq_step_in = step_inc;
                  end
               end
            end
         end
         OP_RESP_FAIL: begin
            if (!link_stopped_ff) begin
               has_result = 1'b1;
               if (shutdown_req_ff || s1_beat_ff.estop) begin
                  link_stopped_in         = 1'b1;
                  rsp_beat_in.deinit_done = 1'b1;
               end else begin
                  seq_step_in = STEP_DIR_WRITE;
                  cmd_on      = 1'b1;
               end
            end
         end
         OP_SET_POWER: begin
            if (s1_beat_ff.power != power_now_ff && !shutdown_req_ff) begin
               power_now_in     = s1_beat_ff.power;
               power_changed_in = 1'b1;
            end
         end
         OP_SHUTDOWN: begin
            shutdown_req_in = 1'b1;
         end
         default: ;
      endcase

      if (!cmd_on) rsp_beat_in.cmd_valid = 1'b0;
      else begin
         rsp_beat_in.cmd_valid   = 1'b1;
         rsp_beat_in.cmd_byte0   = 8'd1;
         rsp_beat_in.cmd_nbytes  = 2'd2;
         rsp_beat_in.resp_expect = 3'd4;
         case (seq_step_in)
            STEP_DIR_WRITE: begin
               rsp_beat_in.cmd_func    = FUNC_CTRL_WRITE;
               rsp_beat_in.cmd_byte1   = ctl_word;
               rsp_beat_in.resp_expect = 3'd2;
            end
            STEP_MAX_READ: begin
               rsp_beat_in.cmd_func  = FUNC_PARAM_READ;
               rsp_beat_in.cmd_byte1 = max_addr_ff;
            end
            STEP_MIN_READ: begin
               rsp_beat_in.cmd_func  = FUNC_PARAM_READ;
               rsp_beat_in.cmd_byte1 = min_addr_ff;
            end
            STEP_RPM_READ: begin
               rsp_beat_in.cmd_func  = FUNC_PARAM_READ;
               rsp_beat_in.cmd_byte1 = rpm_addr_ff;
            end
            STEP_FREQ_WR: begin
               rsp_beat_in.cmd_func    = FUNC_FREQ_WRITE;
               rsp_beat_in.cmd_byte0   = 8'd2;
               rsp_beat_in.cmd_byte1   = freq_word[15:8];
               rsp_beat_in.cmd_byte2   = freq_word[7:0];
               rsp_beat_in.cmd_nbytes  = 2'd3;
               rsp_beat_in.resp_expect = 3'd3;
            end
            STEP_POLL_FREQ: begin
               rsp_beat_in.cmd_func  = FUNC_CTRL_READ;
               rsp_beat_in.cmd_byte1 = STAT_FREQ;
            end
            STEP_POLL_CUR: begin
               rsp_beat_in.cmd_func  = FUNC_CTRL_READ;
               rsp_beat_in.cmd_byte1 = STAT_CURRENT;
            end
            STEP_POLL_RPM: begin
               rsp_beat_in.cmd_func  = FUNC_CTRL_READ;
               rsp_beat_in.cmd_byte1 = STAT_RPM;
            end
            STEP_POLL_TEMP: begin
               rsp_beat_in.cmd_func  = FUNC_CTRL_READ;
               rsp_beat_in.cmd_byte1 = STAT_TEMP;
            end
            default: begin
               // off the sweep: no frame at all
               rsp_beat_in.cmd_valid   = 1'b0;
               rsp_beat_in.cmd_byte0   = 8'd0;
               rsp_beat_in.cmd_nbytes  = 2'd0;
               rsp_beat_in.resp_expect = 3'd0;
            end
         endcase
      end
   end

   // Direction word: run only with power set, no stop pending.
   always_comb begin
      ctl_word = CTL_STOP;
      if (!shutdown_req_in && !s1_beat_ff.estop) begin
         if (power_now_in[15]) ctl_word = CTL_RUN_REV;
         else if (power_now_in != 16'd0) ctl_word = CTL_RUN_FWD;
      end
   end

   // Frequency: |power| (Q1.15) times max frequency, drop the fraction.
   assign power_mag = power_now_in[15] ? (17'h10000 - {1'b0, power_now_in})
                                       : {1'b0, power_now_in};
   assign freq_prod = power_mag * {17'd0, max_freq_in};
   assign freq_word = freq_prod[30:15];

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_step_ff      <= STEP_DIR_WRITE;
         shutdown_req_ff  <= 1'b0;
         power_changed_ff <= 1'b0;
         link_stopped_ff  <= 1'b0;
         power_now_ff     <= '0;
         max_freq_ff      <= '0;
      end else if (s1_advance) begin
         seq_step_ff      <= seq_step_in;
         shutdown_req_ff  <= shutdown_req_in;
         power_changed_ff <= power_changed_in;
         link_stopped_ff  <= link_stopped_in;
         power_now_ff     <= power_now_in;
         max_freq_ff      <= max_freq_in;
      end
   end

   // Result register: load on a producing beat, hold until taken.
   assign rsp_valid_in = (s1_advance & has_result) | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && has_result) rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cmd_valid   = rsp_beat_ff.cmd_valid;
   assign rsp_chan.cmd_func    = rsp_beat_ff.cmd_func;
   assign rsp_chan.cmd_byte0   = rsp_beat_ff.cmd_byte0;
   assign rsp_chan.cmd_byte1   = rsp_beat_ff.cmd_byte1;
   assign rsp_chan.cmd_byte2   = rsp_beat_ff.cmd_byte2;
   assign rsp_chan.cmd_nbytes  = rsp_beat_ff.cmd_nbytes;
   assign rsp_chan.resp_expect = rsp_beat_ff.resp_expect;
   assign rsp_chan.deinit_done = rsp_beat_ff.deinit_done;
   assign rsp_chan.upd_valid   = rsp_beat_ff.upd_valid;
   assign rsp_chan.upd_which   = rsp_beat_ff.upd_which;
   assign rsp_chan.upd_value   = rsp_beat_ff.upd_value;

endmodule

@@ tb/tb_vfd_poll_command_sequencer.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the spindle-drive polling sequencer: directed events, then
// random sweeps, each result checked against a behavioral model of the sweep.
// Depends on vpcs_pkg, vpcs_req_if, vpcs_rsp_if and vfd_poll_command_sequencer.
module tb_vfd_poll_command_sequencer;
   import vpcs_pkg::*;

   localparam int          CLK_PERIOD      = 10;
   localparam int          RESET_CYCLES    = 7;
   localparam int          ITEMS_PER_PHASE = 375;
   localparam int          SETTLE_CYCLES   = 8;     // two-stage pipe plus margin
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          MAX_REPORTS     = 10;
   localparam int unsigned CYCLE_LIMIT     = 300000;

   // op codes the block must ignore
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam rsp_beat_type NO_FRAME = '0;

   // one directed row: the event, and the frame typed in by hand where it is obvious
   typedef struct packed {
      req_beat_type ev;
      logic         typed;
      rsp_beat_type frame;
   } script_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [7:0] csr_wr_data;

   vpcs_req_if req_if ();
   vpcs_rsp_if rsp_if ();

   vfd_poll_command_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------------
   // Sweep model: parameter numbers, sweep position, flags, power and max frequency
   // ---------------------------------------------------------------------------
   logic [7:0]  addr_max = MAX_ADDR_RESET;
   logic [7:0]  addr_min = MIN_ADDR_RESET;
   logic [7:0]  addr_rpm = RPM_ADDR_RESET;
   logic [3:0]  sweep_step = STEP_DIR_WRITE;
   logic        shut_pending = 1'b0;
   logic        power_dirty = 1'b0;
   logic        link_down = 1'b0;
   logic [15:0] power_set = '0;
   logic [15:0] max_freq_raw = '0;

   // expected frames, oldest first
   rsp_beat_type pending_frames[$];

   // stimulus shaping: last command issued and whether a response is owed
   rsp_beat_type last_cmd = NO_FRAME;
   logic         cmd_live = 1'b0;

   int          stage = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned fault_count = 0;
   int unsigned frames_seen = 0;
   int unsigned cycle_count = 0;

   // Fill in the command of the current sweep position.
   function automatic void load_command(inout rsp_beat_type f, input logic estop_now);
      logic [15:0] mag;
      logic [31:0] prod;
      logic [7:0]  ctl;
      f.cmd_valid   = 1'b1;
      f.cmd_byte0   = 8'd1;
      f.cmd_byte2   = 8'd0;
      f.cmd_nbytes  = 2'd2;
      f.resp_expect = 3'd4;
      case (sweep_step)
         STEP_DIR_WRITE: begin
            // direction follows the sign of power unless the link is going down
            ctl = CTL_STOP;
            if (!shut_pending && !estop_now) begin
               if (power_set != 16'd0 && !power_set[15]) ctl = CTL_RUN_FWD;
               else if (power_set[15]) ctl = CTL_RUN_REV;
            end
            f.cmd_func    = FUNC_CTRL_WRITE;
            f.cmd_byte1   = ctl;
            f.resp_expect = 3'd2;
         end
         STEP_MAX_READ: begin
            f.cmd_func  = FUNC_PARAM_READ;
            f.cmd_byte1 = addr_max;
         end
         STEP_MIN_READ: begin
            f.cmd_func  = FUNC_PARAM_READ;
            f.cmd_byte1 = addr_min;
         end
         STEP_RPM_READ: begin
            f.cmd_func  = FUNC_PARAM_READ;
            f.cmd_byte1 = addr_rpm;
         end
         STEP_FREQ_WR: begin
            // |power| in Q1.15 times max frequency; -32768 gives a magnitude of 32768
            mag  = power_set[15] ? (16'd0 - power_set) : power_set;
            prod = 32'(mag) * 32'(max_freq_raw);
            f.cmd_func    = FUNC_FREQ_WRITE;
            f.cmd_byte0   = 8'd2;
            f.cmd_byte1   = prod[30:23];
            f.cmd_byte2   = prod[22:15];
            f.cmd_nbytes  = 2'd3;
            f.resp_expect = 3'd3;
         end
         STEP_POLL_FREQ: begin
            f.cmd_func  = FUNC_CTRL_READ;
            f.cmd_byte1 = STAT_FREQ;
         end
         STEP_POLL_CUR: begin
            f.cmd_func  = FUNC_CTRL_READ;
            f.cmd_byte1 = STAT_CURRENT;
         end
         STEP_POLL_RPM: begin
            f.cmd_func  = FUNC_CTRL_READ;
            f.cmd_byte1 = STAT_RPM;
         end
         STEP_POLL_TEMP: begin
            f.cmd_func  = FUNC_CTRL_READ;
            f.cmd_byte1 = STAT_TEMP;
         end
         default: begin
            // unreachable position: no command at all
            f.cmd_valid   = 1'b0;
            f.cmd_byte0   = 8'd0;
            f.cmd_nbytes  = 2'd0;
            f.resp_expect = 3'd0;
         end
      endcase
   endfunction

   function automatic void mark_update(inout rsp_beat_type f, input logic [2:0] which,
                                       input logic [15:0] value);
      f.upd_valid = 1'b1;
      f.upd_which = which;
      f.upd_value = value;
   endfunction

   // Advance the model by one event; return 1 and the frame if the event has a result.
   function automatic logic predict_frame(input req_beat_type ev, output rsp_beat_type fr);
      logic [15:0] word;
      logic        count_ok;
      fr   = NO_FRAME;
      word = {ev.resp_word_hi, ev.resp_word_lo};
      case (ev.op)
         OP_START: begin
            sweep_step   = STEP_DIR_WRITE;
            shut_pending = 1'b0;
            power_dirty  = 1'b0;
            link_down    = 1'b0;
            power_set    = '0;
            max_freq_raw = '0;
            load_command(fr, ev.estop);
            return 1'b1;
         end
         OP_RESP_OK: begin
            if (link_down) return 1'b0;
            // length byte 255 can never check out: the count would have to be 256
            count_ok = (9'(ev.resp_count) == 9'(ev.resp_len_byte) + 9'd1);
            if (count_ok) begin
               if (ev.resp_func == FUNC_PARAM_READ) begin
                  // max wins over min, min over rated when parameter numbers coincide
                  if (ev.resp_first == addr_max) begin
                     max_freq_raw = word;
                     mark_update(fr, UPD_MAX_FREQ, word);
                  end else if (ev.resp_first == addr_min) begin
                     mark_update(fr, UPD_MIN_FREQ, word);
                  end else if (ev.resp_first == addr_rpm) begin
                     mark_update(fr, UPD_RPM_RATED, word);
                  end
               end else if (ev.resp_func == FUNC_CTRL_WRITE) begin
                  mark_update(fr, UPD_STATUS, {8'h00, ev.resp_first});
               end else if (ev.resp_func == FUNC_CTRL_READ) begin
                  case (ev.resp_first)
                     STAT_FREQ:    mark_update(fr, UPD_FREQ, word);
                     STAT_CURRENT: mark_update(fr, UPD_CURRENT, word);
                     STAT_RPM:     mark_update(fr, UPD_RPM, word);
                     STAT_TEMP:    mark_update(fr, UPD_TEMP, word);
                     default: ;
                  endcase
               end
               if (ev.resp_func == FUNC_CTRL_WRITE && (shut_pending || ev.estop)) begin
                  link_down      = 1'b1;
                  fr.deinit_done = 1'b1;
                  return 1'b1;
               end
               // end of sweep: full sweep again if anything changed, else poll only
               if (sweep_step == STEP_POLL_TEMP) begin
                  sweep_step  = (shut_pending || power_dirty) ? STEP_DIR_WRITE
                                                               : STEP_POLL_FREQ;
                  power_dirty = 1'b0;
               end else begin
                  sweep_step = sweep_step + 4'd1;
               end
            end
            // a bad count falls through and repeats the current command
            load_command(fr, ev.estop);
            return 1'b1;
         end
         OP_RESP_FAIL: begin
            if (link_down) return 1'b0;
            if (shut_pending || ev.estop) begin
               link_down      = 1'b1;
               fr.deinit_done = 1'b1;
               return 1'b1;
            end
            sweep_step = STEP_DIR_WRITE;
            load_command(fr, ev.estop);
            return 1'b1;
         end
         OP_SET_POWER: begin
            if (ev.power != power_set && !shut_pending) begin
               power_set   = ev.power;
               power_dirty = 1'b1;
            end
            return 1'b0;
         end
         OP_SHUTDOWN: begin
            shut_pending = 1'b1;
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic req_beat_type mk_ev(input logic [2:0] op, input logic estop,
                                          input logic [15:0] power, input logic [7:0] func,
                                          input logic [7:0] cnt, input logic [7:0] len,
                                          input logic [7:0] first, input logic [15:0] word);
      return {op, estop, power, func, cnt, len, first, word};
   endfunction

   function automatic rsp_beat_type typed_frame(input logic cmd, input logic [7:0] func,
                                                input logic [7:0] b1, input logic [2:0] ex,
                                                input logic deinit, input logic upd,
                                                input logic [2:0] which,
                                                input logic [15:0] value);
      rsp_beat_type f;
      f             = NO_FRAME;
      f.cmd_valid   = cmd;
      f.cmd_func    = func;
      f.cmd_byte0   = cmd ? 8'd1 : 8'd0;
      f.cmd_byte1   = b1;
      f.cmd_nbytes  = cmd ? 2'd2 : 2'd0;
      f.resp_expect = ex;
      f.deinit_done = deinit;
      f.upd_valid   = upd;
      f.upd_which   = which;
      f.upd_value   = value;
      return f;
   endfunction

   // Mostly well-formed answers to the last command, the rest noise and broken frames.
   function automatic req_beat_type next_random_event();
      req_beat_type ev;
      int unsigned  pick;
      ev.op            = 3'($urandom_range(0, 4));
      ev.estop         = ($urandom_range(0, 99) < 4);
      ev.power         = 16'($urandom);
      ev.resp_func     = 8'($urandom);
      ev.resp_count    = 8'($urandom);
      ev.resp_len_byte = 8'($urandom);
      ev.resp_first    = 8'($urandom);
      ev.resp_word_hi  = 8'($urandom);
      ev.resp_word_lo  = 8'($urandom);
      pick             = $urandom_range(0, 99);
      if (link_down || !cmd_live) begin
         // nothing to answer: mostly restart the link
         if (pick < 60) ev.op = OP_START;
         return ev;
      end
      if (pick < 68) begin
         ev.op            = OP_RESP_OK;
         ev.resp_func     = last_cmd.cmd_func;
         ev.resp_len_byte = 8'($urandom_range(0, 254));
         ev.resp_count    = ev.resp_len_byte + 8'd1;
         if (last_cmd.cmd_func != FUNC_CTRL_WRITE && last_cmd.cmd_func != FUNC_FREQ_WRITE
             && $urandom_range(0, 9) != 0)
            ev.resp_first = last_cmd.cmd_byte1;
      end else if (pick < 74) begin
         ev.op = OP_RESP_FAIL;
      end else if (pick < 80) begin
         // right function, random count: nearly always a bad count
         ev.op        = OP_RESP_OK;
         ev.resp_func = last_cmd.cmd_func;
      end else if (pick < 89) begin
         ev.op = OP_SET_POWER;
         case ($urandom_range(0, 7))
            0: ev.power = 16'h7FFF;
            1: ev.power = 16'h8000;
            2: ev.power = 16'h0000;
            3: ev.power = 16'hFFFF;
            4: ev.power = power_set;
            default: ;
         endcase
      end else if (pick < 91) begin
         ev.op = OP_SHUTDOWN;
      end else if (pick < 94) begin
         ev.op = OP_START;
      end else if (pick < 96) begin
         ev.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      return ev;
   endfunction

   // Offer one event after a random gap; hold it until the block takes the beat.
   task automatic send_event(input req_beat_type ev, input logic has,
                             input rsp_beat_type fr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.op            <= ev.op;
      req_if.estop         <= ev.estop;
      req_if.power         <= ev.power;
      req_if.resp_func     <= ev.resp_func;
      req_if.resp_count    <= ev.resp_count;
      req_if.resp_len_byte <= ev.resp_len_byte;
      req_if.resp_first    <= ev.resp_first;
      req_if.resp_word_hi  <= ev.resp_word_hi;
      req_if.resp_word_lo  <= ev.resp_word_lo;
      do @(posedge clock); while (!req_if.ready);
      if (has) begin
         pending_frames.push_back(fr);
         cmd_live = fr.cmd_valid;
         if (fr.cmd_valid) last_cmd = fr;
      end
   endtask

   // Drop valid, wait for every expected frame, then let events without a result drain.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_frames.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_addr_regs(input logic [7:0] a_max, input logic [7:0] a_min,
                                 input logic [7:0] a_rpm);
      logic [1:0] idx  [3];
      logic [7:0] vals [3];
      int         k;
      idx  = '{CSR_MAX_ADDR, CSR_MIN_ADDR, CSR_RPM_ADDR};
      vals = '{a_max, a_min, a_rpm};
      wait_drained();
      for (k = 0; k < 3; k++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= idx[k];
         csr_wr_data <= vals[k];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      addr_max = a_max;
      addr_min = a_min;
      addr_rpm = a_rpm;
   endtask

   task automatic log_fault(input string what);
      fault_count++;
      if (fault_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, what);
   endtask

   function automatic string frame_diff(input rsp_beat_type want, input rsp_beat_type got);
      string s;
      s = "";
      if (got.cmd_valid   !== want.cmd_valid)   s = {s, " cmd_valid"};
      if (got.cmd_func    !== want.cmd_func)    s = {s, " cmd_func"};
      if (got.cmd_byte0   !== want.cmd_byte0)   s = {s, " cmd_byte0"};
      if (got.cmd_byte1   !== want.cmd_byte1)   s = {s, " cmd_byte1"};
      if (got.cmd_byte2   !== want.cmd_byte2)   s = {s, " cmd_byte2"};
      if (got.cmd_nbytes  !== want.cmd_nbytes)  s = {s, " cmd_nbytes"};
      if (got.resp_expect !== want.resp_expect) s = {s, " resp_expect"};
      if (got.deinit_done !== want.deinit_done) s = {s, " deinit_done"};
      if (got.upd_valid   !== want.upd_valid)   s = {s, " upd_valid"};
      if (got.upd_which   !== want.upd_which)   s = {s, " upd_which"};
      if (got.upd_value   !== want.upd_value)   s = {s, " upd_value"};
      return s;
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: ready with random stalls, one long hold-off in the last phase
   // ---------------------------------------------------------------------------
   initial begin : rsp_drive
      int unsigned hold_left;
      logic        held;
      hold_left = 0;
      held      = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         // hold off long enough for the block to fill and back-pressure its input
         if (stage == 2 && !held) begin
            held      = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Check every result beat against the oldest expected frame.
   always @(posedge clock) begin : rsp_check
      rsp_beat_type got;
      rsp_beat_type want;
      string        bad;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.cmd_valid, rsp_if.cmd_func, rsp_if.cmd_byte0, rsp_if.cmd_byte1,
                rsp_if.cmd_byte2, rsp_if.cmd_nbytes, rsp_if.resp_expect,
                rsp_if.deinit_done, rsp_if.upd_valid, rsp_if.upd_which, rsp_if.upd_value};
         if (pending_frames.size() == 0) begin
            log_fault($sformatf("unexpected result beat %h", got));
         end else begin
            want = pending_frames.pop_front();
            bad  = frame_diff(want, got);
            if (bad != "")
               log_fault($sformatf("result %0d mismatch in%s: expected %h actual %h",
                                   frames_seen, bad, want, got));
         end
         frames_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      script_row_type script [26];
      req_beat_type   ev;
      rsp_beat_type   fr;
      logic           has;
      int             st;
      int unsigned    busy;

      req_if.valid         <= 1'b0;
      req_if.op            <= OP_START;
      req_if.estop         <= 1'b0;
      req_if.power         <= '0;
      req_if.resp_func     <= '0;
      req_if.resp_count    <= '0;
      req_if.resp_len_byte <= '0;
      req_if.resp_first    <= '0;
      req_if.resp_word_hi  <= '0;
      req_if.resp_word_lo  <= '0;
      csr_wr_en            <= 1'b0;
      csr_index            <= CSR_MAX_ADDR;
      csr_wr_data          <= '0;

      // Walk one sweep by hand with the reset parameter numbers, then the special
      // cases: bad counts, unknown codes, failures, shutdown, emergency stop.
      script = '{
         // start from reset: stop word
         {mk_ev(OP_START, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0, 8'h00, 16'h0000), 1'b1,
          typed_frame(1'b1, FUNC_CTRL_WRITE, CTL_STOP, 3'd2, 1'b0, 1'b0, '0, '0)},
         {mk_ev(OP_SET_POWER, 1'b0, 16'h7FFF, 8'h00, 8'd0, 8'd0, 8'h00, 16'h0000), 1'b0,
          NO_FRAME},
         // direction write answered: status update, then max frequency read
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_CTRL_WRITE, 8'd2, 8'd1, 8'h00, 16'h0000),
          1'b1, typed_frame(1'b1, FUNC_PARAM_READ, MAX_ADDR_RESET, 3'd4, 1'b0, 1'b1,
                            UPD_STATUS, 16'h0000)},
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_PARAM_READ, 8'd4, 8'd3, MAX_ADDR_RESET,
                16'hFFFF), 1'b1,
          typed_frame(1'b1, FUNC_PARAM_READ, MIN_ADDR_RESET, 3'd4, 1'b0, 1'b1,
                      UPD_MAX_FREQ, 16'hFFFF)},
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_PARAM_READ, 8'd255, 8'd254,
                MIN_ADDR_RESET, 16'h0000), 1'b0, NO_FRAME},
         // rated rpm answered with the shortest payload; next is the frequency write
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_PARAM_READ, 8'd1, 8'd0, RPM_ADDR_RESET,
                16'h8001), 1'b0, NO_FRAME},
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_FREQ_WRITE, 8'd3, 8'd2, 8'hFF, 16'hFFFF),
          1'b0, NO_FRAME},
         // bad counts, the length-255 one included: repeat the frequency poll
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_CTRL_READ, 8'd0, 8'd255, STAT_FREQ,
                16'h5555), 1'b0, NO_FRAME},
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_CTRL_READ, 8'd255, 8'd255, STAT_FREQ,
                16'hAAAA), 1'b0, NO_FRAME},
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_CTRL_READ, 8'd4, 8'd3, STAT_FREQ,
                16'h1234), 1'b0, NO_FRAME},
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_CTRL_READ, 8'd4, 8'd3, STAT_CURRENT,
                16'hFFFF), 1'b0, NO_FRAME},
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_CTRL_READ, 8'd4, 8'd3, STAT_RPM,
                16'h0001), 1'b0, NO_FRAME},
         // end of sweep with power changed: back to the direction write
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_CTRL_READ, 8'd4, 8'd3, STAT_TEMP,
                16'h8000), 1'b0, NO_FRAME},
         {mk_ev(OP_SET_POWER, 1'b0, 16'h8000, 8'h00, 8'd0, 8'd0, 8'h00, 16'h0000), 1'b0,
          NO_FRAME},
         {mk_ev(OP_RESP_FAIL, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0, 8'h00, 16'h0000), 1'b0,
          NO_FRAME},
         {mk_ev(OP_SPARE_LO, 1'b1, 16'hFFFF, 8'hFF, 8'd255, 8'd254, 8'hFF, 16'hFFFF),
          1'b0, NO_FRAME},
         // unknown function and unknown address: no update, sweep still advances
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, 8'h99, 8'd4, 8'd3, 8'h01, 16'h7777), 1'b0,
          NO_FRAME},
         {mk_ev(OP_RESP_OK, 1'b1, 16'h0000, FUNC_PARAM_READ, 8'd4, 8'd3, 8'hAA, 16'h0F0F),
          1'b0, NO_FRAME},
         {mk_ev(OP_SHUTDOWN, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0, 8'h00, 16'h0000), 1'b0,
          NO_FRAME},
         {mk_ev(OP_SET_POWER, 1'b0, 16'h0001, 8'h00, 8'd0, 8'd0, 8'h00, 16'h0000), 1'b0,
          NO_FRAME},
         // failure with shutdown pending: link down
         {mk_ev(OP_RESP_FAIL, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0, 8'h00, 16'h0000), 1'b1,
          typed_frame(1'b0, '0, '0, '0, 1'b1, 1'b0, '0, '0)},
         {mk_ev(OP_RESP_OK, 1'b0, 16'h0000, FUNC_CTRL_WRITE, 8'd2, 8'd1, 8'h00, 16'h0000),
          1'b0, NO_FRAME},
         {mk_ev(OP_RESP_FAIL, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0, 8'h00, 16'h0000), 1'b0,
          NO_FRAME},
         // start under emergency stop, then the checked direction write stops the link
         {mk_ev(OP_START, 1'b1, 16'h0000, 8'h00, 8'd0, 8'd0, 8'h00, 16'h0000), 1'b1,
          typed_frame(1'b1, FUNC_CTRL_WRITE, CTL_STOP, 3'd2, 1'b0, 1'b0, '0, '0)},
         {mk_ev(OP_RESP_OK, 1'b1, 16'h0000, FUNC_CTRL_WRITE, 8'd2, 8'd1, 8'hFF, 16'h0000),
          1'b1, typed_frame(1'b0, '0, '0, '0, 1'b1, 1'b1, UPD_STATUS, 16'h00FF)},
         {mk_ev(OP_START, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0, 8'h00, 16'h0000), 1'b1,
          typed_frame(1'b1, FUNC_CTRL_WRITE, CTL_STOP, 3'd2, 1'b0, 1'b0, '0, '0)}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (st = 0; st < 3; st++) begin
         case (st)
            0: begin
               send_idle_pct = 11;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 11;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         if (st == 0) begin
            // hand-typed frames override the model; it still tracks the state
            foreach (script[i]) begin
               has = predict_frame(script[i].ev, fr);
               if (script[i].typed) begin
                  has = 1'b1;
                  fr  = script[i].frame;
               end
               send_event(script[i].ev, has, fr);
            end
         end

         // new parameter numbers each phase: all equal at zero, extremes, random
         case (st)
            0:       load_addr_regs(8'd0, 8'd0, 8'd0);
            1:       load_addr_regs(8'd255, 8'd1, 8'd255);
            default: load_addr_regs(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         stage = st;

         busy = 0;
         while (busy < ITEMS_PER_PHASE) begin
            ev  = next_random_event();
            has = predict_frame(ev, fr);
            send_event(ev, has, fr);
            // dropped responses and spare ops do not count as work
            if (has || ev.op == OP_SET_POWER || ev.op == OP_SHUTDOWN) busy++;
         end
      end

      wait_drained();
      foreach (pending_frames[i])
         log_fault($sformatf("expected frame %h never arrived", pending_frames[i]));

      if (fault_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
